@@ rtl/dsort_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Descending sorter package
// Shared constants, payload types, cell control and controller states.
// ----------------------------------------------------------------------------
package dsort_pkg;

	localparam int MAX_ELEMENTS = 32;
	localparam int VALUE_W      = 32;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last_in;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] sorted_value;
		logic                      last_out;
		logic                      overflow;
	} out_item_t;

	typedef struct packed {
		logic insert;
		logic pop;
	} cell_ctrl_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} dsort_state_t;

endpackage : dsort_pkg
`default_nettype wire

@@ rtl/dsort_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Descending sorter cell
// Holds one element. On insert, if the broadcast element beats its own or the
// cell is empty, takes it (or the previous cell's element, if displaced too),
// handing elements down the row; on pop, takes the element of the next cell.
// ----------------------------------------------------------------------------
module dsort_cell
	import dsort_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire cell_ctrl_t                ctrl,
	input  wire logic signed [VALUE_W-1:0] ins_value,
	input  wire logic signed [VALUE_W-1:0] prev_value,
	input  wire logic                      prev_occ,
	input  wire logic                      prev_greater,
	input  wire logic signed [VALUE_W-1:0] next_value,
	input  wire logic                      next_occ,
	output logic signed [VALUE_W-1:0]      value,
	output logic                           occ,
	output logic                           greater
);

	logic signed [VALUE_W-1:0] value_q;
	logic                      occ_q;

	assign greater = !occ_q || (ins_value > value_q);
	assign value   = value_q;
	assign occ     = occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.insert) begin
			occ_q <= occ_q | prev_occ;
		end else if (ctrl.pop) begin
			occ_q <= next_occ;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (greater) begin
				value_q <= prev_greater ? prev_value : ins_value;
			end
		end else if (ctrl.pop) begin
			value_q <= next_value;
		end
	end

endmodule : dsort_cell
`default_nettype wire

@@ rtl/descending_sorter_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Descending sorter unit
// Systolic row of cells that sorts a set of signed values highest first.
// ----------------------------------------------------------------------------
// While loading, one request is taken per cycle and inserted into a row of
// MAX_ELEMENTS cells that always stays in descending order. The request that
// carries last_in closes the set; the row then drains from its head, one
// result per cycle while out_ready is high. No request is taken while the row
// drains. Requests beyond MAX_ELEMENTS are dropped and every result of that
// set reports overflow. The last result (smallest value) carries last_out.
// ----------------------------------------------------------------------------
module descending_sorter_unit
	import dsort_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);

	dsort_state_t state_q;
	dsort_state_t state_nxt;
	cell_ctrl_t   ctrl;
	logic         accept;
	logic         full;
	logic         pop_last;
	logic         overflow_q;
	logic         out_valid_q;
	out_item_t    out_data_q;

	logic signed [VALUE_W-1:0] value_w [MAX_ELEMENTS];
	logic [MAX_ELEMENTS-1:0]   occ_w;
	logic [MAX_ELEMENTS-1:0]   greater_w;

	for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
		logic signed [VALUE_W-1:0] prev_value;
		logic                      prev_occ;
		logic                      prev_greater;
		logic signed [VALUE_W-1:0] next_value;
		logic                      next_occ;

		if (i == 0) begin : g_head
			assign prev_value   = '0;
			assign prev_occ     = 1'b1;
			assign prev_greater = 1'b0;
		end else begin : g_body
			assign prev_value   = value_w[i-1];
			assign prev_occ     = occ_w[i-1];
			assign prev_greater = greater_w[i-1];
		end

		if (i == MAX_ELEMENTS - 1) begin : g_tail
			assign next_value = '0;
			assign next_occ   = 1'b0;
		end else begin : g_link
			assign next_value = value_w[i+1];
			assign next_occ   = occ_w[i+1];
		end

		dsort_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.ins_value    (in_data.value),
			.prev_value   (prev_value),
			.prev_occ     (prev_occ),
			.prev_greater (prev_greater),
			.next_value   (next_value),
			.next_occ     (next_occ),
			.value        (value_w[i]),
			.occ          (occ_w[i]),
			.greater      (greater_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt   = state_q;
		in_ready    = 1'b0;
		ctrl.insert = 1'b0;
		ctrl.pop    = 1'b0;
		full        = occ_w[MAX_ELEMENTS-1];
		accept      = 1'b0;
		pop_last    = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready    = 1'b1;
				accept      = in_valid;
				ctrl.insert = in_valid && !full;
				if (in_valid && in_data.last_in) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				ctrl.pop = occ_w[0] && (!out_valid_q || out_ready);
				pop_last = ctrl.pop && !occ_w[1];
				if (pop_last) begin
					state_nxt = ST_LOAD;
				end
			end
			default: begin
				state_nxt = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overflow_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_last) begin
				overflow_q <= 1'b0;
			end else if (accept && full) begin
				overflow_q <= 1'b1;
			end
			if (ctrl.pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			out_data_q.sorted_value <= value_w[0];
			out_data_q.last_out     <= !occ_w[1];
			out_data_q.overflow     <= overflow_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTH
	a_occ_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_w & (occ_w + 1'b1)) == '0)
		else $error("occupied cells are not a prefix of the row");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> occ_w[0])
		else $error("row empty while draining");

	a_empty_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop_last |=> occ_w == '0)
		else $error("row not empty after last result");

	a_descending: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop && out_valid_q && !out_data_q.last_out
		|-> value_w[0] <= out_data_q.sorted_value)
		else $error("results out of descending order");
`endif

endmodule : descending_sorter_unit
`default_nettype wire
